@@ rtl/bee_pkg.sv @@
// Package: shared constants, codes and types of the boolean expression evaluator.
`timescale 1ns / 1ps
package bee_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NOT   = 8'h21;
  localparam logic [7:0] CH_AND   = 8'h26;
  localparam logic [7:0] CH_OR    = 8'h7c;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;

  typedef enum logic [1:0] {
    OP_PAREN = 2'd0,
    OP_NOT   = 2'd1,
    OP_AND   = 2'd2,
    OP_OR    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_MALFORMED = 2'd1,
    ERR_OVERFLOW  = 2'd2
  } err_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_RED_CHECK,
    ST_RED_APPLY,
    ST_POP_APPLY,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    AFT_PUSH,
    AFT_CLOSE,
    AFT_END
  } after_t;

endpackage

@@ rtl/bee_sym_if.sv @@
// Interface: input channel carrying one expression character per transaction.
`timescale 1ns / 1ps
interface bee_sym_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       last_symbol;

  modport source (output valid, output symbol, output last_symbol, input ready);
  modport sink (input valid, input symbol, input last_symbol, output ready);
endinterface

@@ rtl/bee_res_if.sv @@
// Interface: result channel carrying the value and status of one expression.
`timescale 1ns / 1ps
interface bee_res_if;
  logic       valid;
  logic       ready;
  logic       value;
  logic [1:0] status;

  modport source (output valid, output value, output status, input ready);
  modport sink (input valid, input value, input status, output ready);
endinterface

@@ rtl/bee_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bee_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

@@ rtl/boolean_expression_evaluator.sv @@
// Top level: shunting-yard boolean expression evaluator with memory-backed stacks.
// Sequencing: a literal, '(', '!' or other character goes through DISPATCH and back to IDLE.
// '&', '|' also pass RED_CHECK, ')' also POP_APPLY; a RED_APPLY per operator reduced (shared step).
// Last character: final reductions, then FINISH loads the result (direct on error) + out stall.
// Flow: one character at a time; the next is accepted only once back in IDLE.
// Reset (rst_n, synchronous): returns to IDLE, clears counts, error and output valid; stacks stay as is.
`timescale 1ns / 1ps
module boolean_expression_evaluator (
  input  logic clk,
  input  logic rst_n,
  bee_sym_if.sink   in_ch,
  bee_res_if.source out_ch
);
  import bee_pkg::*;

  state_t           state_r, state_nxt;
  logic [7:0]       sym_r, sym_nxt;
  logic             last_r, last_nxt;
  op_t              limit_r, limit_nxt;
  after_t           after_r, after_nxt;
  op_t              push_code_r, push_code_nxt;
  logic [CNT_W-1:0] op_cnt_r, op_cnt_nxt;
  logic [CNT_W-1:0] val_cnt_r, val_cnt_nxt;
  op_t              op_top_r, op_top_nxt;
  logic             val_top_r, val_top_nxt;
  err_t             err_r, err_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_value_r, out_value_nxt;
  err_t             out_status_r, out_status_nxt;

  logic             op_we, val_we;
  logic [1:0]       op_rdata;
  logic             val_rdata;
  logic [CNT_W-1:0] op_cnt_m1, op_cnt_m2, val_cnt_m1, val_cnt_m2;
  logic             push_op_req, push_val_req, push_val_bit, can_reduce;
  op_t              push_op_code;

  assign op_cnt_m1  = op_cnt_r - CNT_W'(1);
  assign op_cnt_m2  = op_cnt_r - CNT_W'(2);
  assign val_cnt_m1 = val_cnt_r - CNT_W'(1);
  assign val_cnt_m2 = val_cnt_r - CNT_W'(2);

  assign can_reduce = (err_r == ERR_NONE) && (op_cnt_r != '0) &&
                      (op_top_r != OP_PAREN) && (op_top_r <= limit_r);

  bee_ram #(.WIDTH(2), .DEPTH(STACK_DEPTH)) u_op_ram (
    .clk   (clk),
    .we    (op_we),
    .waddr (op_cnt_m1[PTR_W-1:0]),
    .wdata (op_top_r),
    .raddr (op_cnt_m2[PTR_W-1:0]),
    .rdata (op_rdata)
  );

  bee_ram #(.WIDTH(1), .DEPTH(STACK_DEPTH)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_cnt_m1[PTR_W-1:0]),
    .wdata (val_top_r),
    .raddr (val_cnt_m2[PTR_W-1:0]),
    .rdata (val_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_cnt_r    <= '0;
      val_cnt_r   <= '0;
      err_r       <= ERR_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_cnt_r    <= op_cnt_nxt;
      val_cnt_r   <= val_cnt_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r        <= sym_nxt;
    last_r       <= last_nxt;
    limit_r      <= limit_nxt;
    after_r      <= after_nxt;
    push_code_r  <= push_code_nxt;
    op_top_r     <= op_top_nxt;
    val_top_r    <= val_top_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    sym_nxt        = sym_r;
    last_nxt       = last_r;
    limit_nxt      = limit_r;
    after_nxt      = after_r;
    push_code_nxt  = push_code_r;
    op_cnt_nxt     = op_cnt_r;
    val_cnt_nxt    = val_cnt_r;
    op_top_nxt     = op_top_r;
    val_top_nxt    = val_top_r;
    err_nxt        = err_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    op_we          = 1'b0;
    val_we         = 1'b0;
    push_op_req    = 1'b0;
    push_op_code   = OP_PAREN;
    push_val_req   = 1'b0;
    push_val_bit   = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          sym_nxt   = in_ch.symbol;
          last_nxt  = in_ch.last_symbol;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (err_r != ERR_NONE) begin
          state_nxt = last_r ? ST_FINISH : ST_IDLE;
        end else begin
          limit_nxt = OP_OR;
          after_nxt = AFT_END;
          state_nxt = last_r ? ST_RED_CHECK : ST_IDLE;
          case (sym_r)
            CH_ZERO: begin
              push_val_req = 1'b1;
              push_val_bit = 1'b0;
            end
            CH_ONE: begin
              push_val_req = 1'b1;
              push_val_bit = 1'b1;
            end
            CH_OPEN: begin
              push_op_req  = 1'b1;
              push_op_code = OP_PAREN;
            end
            CH_NOT: begin
              push_op_req  = 1'b1;
              push_op_code = OP_NOT;
            end
            CH_AND: begin
              limit_nxt     = OP_AND;
              after_nxt     = AFT_PUSH;
              push_code_nxt = OP_AND;
              state_nxt     = ST_RED_CHECK;
            end
            CH_OR: begin
              after_nxt     = AFT_PUSH;
              push_code_nxt = OP_OR;
              state_nxt     = ST_RED_CHECK;
            end
            CH_CLOSE: begin
              after_nxt = AFT_CLOSE;
              state_nxt = ST_RED_CHECK;
            end
            default: begin
            end
          endcase
        end
      end
      ST_RED_CHECK: begin
        if (can_reduce) begin
          state_nxt = ST_RED_APPLY;
        end else begin
          case (after_r)
            AFT_PUSH: begin
              if (err_r == ERR_NONE) begin
                push_op_req  = 1'b1;
                push_op_code = push_code_r;
              end
              limit_nxt = OP_OR;
              after_nxt = AFT_END;
              state_nxt = last_r ? ST_RED_CHECK : ST_IDLE;
            end
            AFT_CLOSE: begin
              limit_nxt = OP_OR;
              after_nxt = AFT_END;
              state_nxt = last_r ? ST_RED_CHECK : ST_IDLE;
              if (err_r == ERR_NONE) begin
                if (op_cnt_r == '0) begin
                  err_nxt = ERR_MALFORMED;
                end else begin
                  state_nxt = ST_POP_APPLY;
                end
              end
            end
            default: begin
              if (err_r == ERR_NONE &&
                  (op_cnt_r != '0 || val_cnt_r != CNT_W'(1))) begin
                err_nxt = ERR_MALFORMED;
              end
              state_nxt = ST_FINISH;
            end
          endcase
        end
      end
      ST_RED_APPLY: begin
        op_cnt_nxt = op_cnt_m1;
        op_top_nxt = op_t'(op_rdata);
        if (op_top_r == OP_NOT) begin
          if (val_cnt_r == '0) begin
            err_nxt = ERR_MALFORMED;
          end else begin
            val_top_nxt = !val_top_r;
          end
        end else begin
          if (val_cnt_r < CNT_W'(2)) begin
            err_nxt = ERR_MALFORMED;
          end else begin
            val_top_nxt = (op_top_r == OP_AND) ? (val_top_r & val_rdata)
                                               : (val_top_r | val_rdata);
            val_cnt_nxt = val_cnt_m1;
          end
        end
        state_nxt = ST_RED_CHECK;
      end
      ST_POP_APPLY: begin
        op_cnt_nxt = op_cnt_m1;
        op_top_nxt = op_t'(op_rdata);
        state_nxt  = last_r ? ST_RED_CHECK : ST_IDLE;
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = (err_r == ERR_NONE) && val_top_r;
          out_status_nxt = err_r;
          op_cnt_nxt     = '0;
          val_cnt_nxt    = '0;
          err_nxt        = ERR_NONE;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (push_val_req) begin
      if (val_cnt_r >= CNT_W'(STACK_DEPTH)) begin
        err_nxt = ERR_OVERFLOW;
      end else begin
        val_we      = (val_cnt_r != '0);
        val_top_nxt = push_val_bit;
        val_cnt_nxt = val_cnt_r + CNT_W'(1);
      end
    end
    if (push_op_req) begin
      if (op_cnt_r >= CNT_W'(STACK_DEPTH)) begin
        err_nxt = ERR_OVERFLOW;
      end else begin
        op_we      = (op_cnt_r != '0);
        op_top_nxt = push_op_code;
        op_cnt_nxt = op_cnt_r + CNT_W'(1);
      end
    end
  end

  assign in_ch.ready   = (state_r == ST_IDLE);
  assign out_ch.valid  = out_valid_r;
  assign out_ch.value  = out_value_r;
  assign out_ch.status = out_status_r;
endmodule

@@ rtl/bee_chk.sv @@
// Checker: port-level assertions on the evaluator, bound to the top level.
`timescale 1ns / 1ps
module bee_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_value,
  input logic [1:0] out_status
);
  import bee_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_value) && $stable(out_status))
    else $error("result payload changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ERR_NONE || out_status == ERR_MALFORMED ||
                   out_status == ERR_OVERFLOW))
    else $error("invalid status code");

  a_err_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ERR_NONE |-> !out_value)
    else $error("nonzero value with error status");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready held after a transaction");
endmodule

bind boolean_expression_evaluator bee_chk u_bee_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_value  (out_ch.value),
  .out_status (out_ch.status)
);

@@ tb/tb_top.sv @@
// Testbench: random and directed infix boolean expressions checked against a stack predictor.
`timescale 1ns / 1ps
module tb_top;
  import bee_pkg::*;

  localparam int ITEM_TARGET = 2000;
  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 300;

  typedef struct packed {
    logic value;
    err_t status;
  } answer_t;

  class expr_checker;
    op_t op_stack[STACK_DEPTH];
    bit val_stack[STACK_DEPTH];
    int unsigned n_ops;
    int unsigned n_vals;
    err_t err;
    answer_t answers[$];
    int unsigned faults;

    function new();
      faults = 0;
      clear();
    endfunction

    function void clear();
      n_ops = 0;
      n_vals = 0;
      err = ERR_NONE;
    endfunction

    function void flag(err_t e);
      if (err == ERR_NONE) err = e;
    endfunction

    function void push_val(bit v);
      if (n_vals >= STACK_DEPTH) begin
        flag(ERR_OVERFLOW);
      end else begin
        val_stack[n_vals] = v;
        n_vals++;
      end
    endfunction

    function void push_op(op_t op);
      if (n_ops >= STACK_DEPTH) begin
        flag(ERR_OVERFLOW);
      end else begin
        op_stack[n_ops] = op;
        n_ops++;
      end
    endfunction

    function void apply_top();
      op_t op;
      op = op_stack[n_ops-1];
      n_ops--;
      if (op == OP_NOT) begin
        if (n_vals < 1) flag(ERR_MALFORMED);
        else val_stack[n_vals-1] = !val_stack[n_vals-1];
      end else if (n_vals < 2) begin
        flag(ERR_MALFORMED);
      end else begin
        n_vals--;
        val_stack[n_vals-1] = (op == OP_AND) ? (val_stack[n_vals] & val_stack[n_vals-1])
                                             : (val_stack[n_vals] | val_stack[n_vals-1]);
      end
    endfunction

    // reduce while the top operator binds at least as tightly as limit
    function void fold(op_t limit);
      op_t top;
      while (err == ERR_NONE && n_ops > 0) begin
        top = op_stack[n_ops-1];
        if (top == OP_PAREN || top > limit) break;
        apply_top();
      end
    endfunction

    function void note_symbol(logic [7:0] s, logic is_last);
      answer_t a;
      if (err == ERR_NONE) begin
        case (s)
          CH_ZERO: push_val(1'b0);
          CH_ONE: push_val(1'b1);
          CH_OPEN: push_op(OP_PAREN);
          CH_NOT: push_op(OP_NOT);
          CH_AND: begin
            fold(OP_AND);
            if (err == ERR_NONE) push_op(OP_AND);
          end
          CH_OR: begin
            fold(OP_OR);
            if (err == ERR_NONE) push_op(OP_OR);
          end
          CH_CLOSE: begin
            fold(OP_OR);
            if (err == ERR_NONE) begin
              if (n_ops == 0) flag(ERR_MALFORMED);
              else n_ops--;
            end
          end
          default: ;
        endcase
      end
      if (is_last) begin
        fold(OP_OR);
        if (err == ERR_NONE && n_ops != 0) flag(ERR_MALFORMED);
        if (err == ERR_NONE && n_vals != 1) flag(ERR_MALFORMED);
        a.status = err;
        a.value = (err == ERR_NONE) ? val_stack[0] : 1'b0;
        answers.insert(answers.size(), a);
        clear();
      end
    endfunction

    function void report(string msg);
      faults++;
      if (faults <= 10) $display("%s", msg);
    endfunction

    function void check_result(logic v, logic [1:0] st);
      answer_t a;
      if (answers.size() == 0) begin
        report($sformatf("unexpected transaction: value %0d status %0d", v, st));
      end else begin
        a = answers.pop_front();
        if (v !== a.value || st !== a.status)
          report($sformatf("mismatch: expected value %0d status %0d, got value %0d status %0d",
                           a.value, a.status, v, st));
      end
    endfunction

    function int unsigned pending();
      return answers.size();
    endfunction

    function bit passed();
      return faults == 0 && answers.size() == 0;
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bee_sym_if in_ch ();
  bee_res_if out_ch ();

  boolean_expression_evaluator dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  expr_checker sb = new();
  logic [7:0] expr_q[$];
  bit calm;
  int unsigned symbols_sent;
  int unsigned quiet = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void add_symbol(logic [7:0] s);
    expr_q.insert(expr_q.size(), s);
  endfunction

  function automatic logic [7:0] pick_token();
    case ($urandom_range(0, 6))
      0: return CH_ZERO;
      1: return CH_ONE;
      2: return CH_NOT;
      3: return CH_AND;
      4: return CH_OR;
      5: return CH_OPEN;
      default: return CH_CLOSE;
    endcase
  endfunction

  function automatic logic [7:0] rand_ignored();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (b inside {CH_ZERO, CH_ONE, CH_NOT, CH_AND, CH_OR, CH_OPEN, CH_CLOSE});
    return b;
  endfunction

  task automatic gen_operand(int depth);
    if ($urandom_range(0, 19) == 0) add_symbol(rand_ignored());
    case ($urandom_range(0, 3))
      0: begin
        add_symbol(CH_NOT);
        gen_operand(depth);
      end
      1: begin
        if (depth > 0) begin
          add_symbol(CH_OPEN);
          gen_expr(depth - 1);
          add_symbol(CH_CLOSE);
        end else begin
          add_symbol($urandom_range(0, 1) ? CH_ONE : CH_ZERO);
        end
      end
      default: add_symbol($urandom_range(0, 1) ? CH_ONE : CH_ZERO);
    endcase
  endtask

  task automatic gen_expr(int depth);
    int n;
    n = (depth > 0) ? $urandom_range(0, 3) : 0;
    gen_operand(depth);
    repeat (n) begin
      add_symbol($urandom_range(0, 1) ? CH_AND : CH_OR);
      gen_operand(depth);
    end
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_symbol(s[i]);
  endtask

  task automatic send_symbol(logic [7:0] s, logic is_last);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 17);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.symbol <= s;
    in_ch.last_symbol <= is_last;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_expr();
    for (int i = 0; i < expr_q.size(); i++) send_symbol(expr_q[i], i == expr_q.size() - 1);
    symbols_sent += expr_q.size();
    expr_q.delete();
  endtask

  initial begin
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      stall = calm ? 0 : $urandom_range(0, 17);
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) sb.note_symbol(in_ch.symbol, in_ch.last_symbol);
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.value, out_ch.status);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  initial begin
    string directed[];
    int kind;
    int n;
    int pos;
    directed = '{"1", "!!1", "0|1&0", "(1|0)&!0", "1!", "1&", "&1", "1)",
                 "(1", "11", " ", ")1&1"};
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.symbol = 8'h00;
    in_ch.last_symbol = 1'b0;
    calm = 1'b0;
    symbols_sent = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      add_text(directed[i]);
      send_expr();
    end
    add_symbol(8'h00);
    add_symbol(CH_ONE);
    add_symbol(8'hFF);
    send_expr();

    while (symbols_sent < ITEM_TARGET) begin
      calm = ($urandom_range(0, 7) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        gen_expr($urandom_range(0, 5));
      end else if (kind < 85) begin
        gen_expr($urandom_range(1, 4));
        pos = $urandom_range(0, expr_q.size() - 1);
        case ($urandom_range(0, 2))
          0: expr_q.delete(pos);
          1: expr_q.insert(pos, pick_token());
          default: expr_q[pos] = pick_token();
        endcase
        if (expr_q.size() == 0) add_symbol(pick_token());
      end else if (kind < 95) begin
        repeat ($urandom_range(1, 8))
          add_symbol($urandom_range(0, 1) ? pick_token() : 8'($urandom_range(0, 255)));
      end else begin
        // push either stack to just below, at or past its depth
        n = $urandom_range(STACK_DEPTH - 4, STACK_DEPTH + 6);
        case ($urandom_range(0, 2))
          0: begin
            repeat (n) add_symbol(CH_OPEN);
            add_symbol(CH_ONE);
            repeat (n) add_symbol(CH_CLOSE);
          end
          1: repeat (n) add_symbol($urandom_range(0, 1) ? CH_ONE : CH_ZERO);
          default: begin
            repeat (n) add_symbol(CH_NOT);
            add_symbol(CH_ZERO);
          end
        endcase
      end
      send_expr();
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    calm = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.passed()) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
